// ===== rtl/macd_ema_stream_top_assert.svh =====
// ----------------------------------------------------------------------------
// MACD EMA stream assertion macros
// Concurrent assertion wrappers shared by the block; empty for synthesis.
// ----------------------------------------------------------------------------
`ifndef MACD_EMA_STREAM_TOP_ASSERT_SVH
`define MACD_EMA_STREAM_TOP_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication, disabled during reset
`define MACDEMA_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define MACDEMA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`else

`define MACDEMA_ASSERT_SAME(label, clk, rst, ante, cons, msg)
`define MACDEMA_ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

// ===== rtl/macdema_pkg.sv =====
// ----------------------------------------------------------------------------
// MACD EMA stream package
// Shared widths, register indexes, reset values and divider status type.
// ----------------------------------------------------------------------------
package macdema_pkg;

  // default parameter values
  localparam int PERIOD_MAX_DEF = 256;
  localparam int PRICE_BITS_DEF = 32;

  // divider widths that follow from the defaults
  localparam int ACC_BITS_DEF = PRICE_BITS_DEF + $clog2(PERIOD_MAX_DEF + 1) + 3;
  localparam int DEN_BITS_DEF = $clog2(PERIOD_MAX_DEF + 2);

  // configuration port
  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = 9;

  localparam logic [CFG_INDEX_BITS-1:0] REG_FAST   = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SLOW   = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SIGNAL = 2'd2;

  localparam int FAST_PERIOD_BITS = 8;
  localparam int SLOW_PERIOD_BITS = 9;
  localparam int SIGNAL_LEN_BITS  = 9;

  localparam logic [FAST_PERIOD_BITS-1:0] FAST_PERIOD_RST = 8'd12;
  localparam logic [SLOW_PERIOD_BITS-1:0] SLOW_PERIOD_RST = 9'd26;
  localparam logic [SIGNAL_LEN_BITS-1:0]  SIGNAL_LEN_RST  = 9'd9;

  // sample counter saturates here
  localparam int                    COUNT_BITS = 10;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX  = 10'd1023;

  // divider status toward the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

// ===== rtl/macdema_in_if.sv =====
// ----------------------------------------------------------------------------
// MACD EMA stream input channel
// Valid/ready channel carrying one price sample per transaction.
// ----------------------------------------------------------------------------
interface macdema_in_if #(
  parameter int PRICE_BITS = macdema_pkg::PRICE_BITS_DEF
);
  logic                  valid;
  logic                  ready;
  logic [PRICE_BITS-1:0] price;
  logic                  series_start;

  modport source (output valid, output price, output series_start, input ready);
  modport sink (input valid, input price, input series_start, output ready);
endinterface

// ===== rtl/macdema_out_if.sv =====
// ----------------------------------------------------------------------------
// MACD EMA stream result channel
// Valid/ready channel carrying one MACD result per transaction.
// ----------------------------------------------------------------------------
interface macdema_out_if #(
  parameter int PRICE_BITS = macdema_pkg::PRICE_BITS_DEF
);
  logic                       valid;
  logic                       ready;
  logic                       macd_valid;
  logic signed [PRICE_BITS:0]   macd_value;
  logic                       signal_valid;
  logic signed [PRICE_BITS:0]   signal_value;
  logic signed [PRICE_BITS+1:0] histogram_value;
  logic                       period_error;

  modport source (
    output valid, output macd_valid, output macd_value, output signal_valid,
    output signal_value, output histogram_value, output period_error, input ready
  );
  modport sink (
    input valid, input macd_valid, input macd_value, input signal_valid,
    input signal_value, input histogram_value, input period_error, output ready
  );
endinterface

// ===== rtl/macd_ema_stream_top.sv =====
// ----------------------------------------------------------------------------
// MACD EMA stream top level
// Fast and slow price averages, MACD, signal line and histogram per sample.
// ----------------------------------------------------------------------------
// Usage:
//   samples carries one price per transaction; series_start clears the running
//   averages before that price is used. results returns exactly one item per
//   sample with validity flags for MACD and for the signal line/histogram.
//   The user must write periods on the cfg_wr_en/cfg_index/cfg_data port only
//   while idle; the block itself does not enforce this.
// Sequencing:
//   the block takes one sample at a time and drops ready until its result is
//   in the output register. The fast, slow and signal updates use the single
//   shared restoring divider in turn, one quotient bit per cycle. While an
//   average is still summing its seed it skips the divider; an item with a
//   period error skips all three updates and goes straight to the output.
// Reset:
//   synchronous rst restores the default periods (12, 26, 9) and clears the
//   sample count and all three accumulators.
// Stall:
//   a finished result waits in the output register; the next sample may be
//   accepted and computed meanwhile, and the sequencer holds before writing
//   its result until the register has been taken.
// ----------------------------------------------------------------------------
`include "macd_ema_stream_top_assert.svh"

module macd_ema_stream_top #(
  parameter int PERIOD_MAX = macdema_pkg::PERIOD_MAX_DEF,
  parameter int PRICE_BITS = macdema_pkg::PRICE_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  macdema_in_if.sink                             samples,
  macdema_out_if.source                          results,
  input  logic                                   cfg_wr_en,
  input  logic [macdema_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [macdema_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
  import macdema_pkg::*;

  localparam int PW       = $clog2(PERIOD_MAX + 1);
  localparam int DEN_BITS = $clog2(PERIOD_MAX + 2);
  localparam int CMPW     = ((PW > COUNT_BITS) ? PW : COUNT_BITS) + 1;
  localparam int ACC_BITS = PRICE_BITS + PW + 3;

  localparam logic signed [ACC_BITS-1:0] MACD_HI =
    {{(ACC_BITS - PRICE_BITS){1'b0}}, {PRICE_BITS{1'b1}}};
  localparam logic signed [ACC_BITS-1:0] MACD_LO =
    {{(ACC_BITS - PRICE_BITS){1'b1}}, {PRICE_BITS{1'b0}}};

  typedef enum logic [2:0] {S_IDLE, S_PREP, S_DIV, S_MACD, S_OUT} state_t;
  typedef enum logic [1:0] {U_FAST, U_SLOW, U_SIG} unit_t;

  // register value 0 counts as 1, values above the maximum are clamped
  function automatic logic [PW-1:0] eff_period(input logic [CFG_DATA_BITS-1:0] r);
    logic [PW-1:0] e;
    if (r == '0) e = PW'(1);
    else if (int'(r) > PERIOD_MAX) e = PW'(PERIOD_MAX);
    else e = PW'(r);
    return e;
  endfunction

  // configuration registers
  logic [FAST_PERIOD_BITS-1:0] fast_period;
  logic [SLOW_PERIOD_BITS-1:0] slow_period;
  logic [SIGNAL_LEN_BITS-1:0]  signal_len;

  // sequencer and running state
  state_t                     state;
  unit_t                      unit;
  logic [COUNT_BITS-1:0]      count;
  logic signed [ACC_BITS-1:0] fast_acc;
  logic signed [ACC_BITS-1:0] slow_acc;
  logic signed [ACC_BITS-1:0] sig_acc;
  logic [PRICE_BITS-1:0]      price_q;
  logic                       item_err;
  logic                       addback;
  logic signed [PRICE_BITS:0] macd_q;

  // output register
  logic                         out_valid;
  logic                         out_mv;
  logic signed [PRICE_BITS:0]   out_macd;
  logic                         out_sv;
  logic signed [PRICE_BITS:0]   out_sig;
  logic signed [PRICE_BITS+1:0] out_hist;
  logic                         out_perr;

  logic [PW-1:0]   fast_eff;
  logic [PW-1:0]   slow_eff;
  logic [PW-1:0]   sig_eff;
  logic            period_err_now;
  logic [CMPW-1:0] count_ext;
  logic [CMPW-1:0] k_pos;
  logic            macd_on;
  logic            sig_on;
  logic            accept;

  logic [COUNT_BITS-1:0] count_base;
  logic [COUNT_BITS-1:0] count_inc;

  logic signed [ACC_BITS-1:0] acc_cur;
  logic signed [ACC_BITS-1:0] x_cur;
  logic [CMPW-1:0]            pos_cur;
  logic [PW-1:0]              n_cur;
  logic signed [ACC_BITS-1:0] sum_cur;
  logic signed [ACC_BITS-1:0] diff2;
  logic                       pos_lt;
  logic                       pos_eq;
  logic [DEN_BITS-1:0]        n_den;
  logic [DEN_BITS-1:0]        div_den;
  logic signed [ACC_BITS-1:0] div_num;
  logic                       div_start;
  logic signed [ACC_BITS-1:0] div_quot;
  div_status_t                div_stat;
  logic signed [ACC_BITS-1:0] div_update;

  state_t                     adv_state;
  unit_t                      adv_unit;
  logic signed [ACC_BITS-1:0] macd_diff;
  logic signed [ACC_BITS-1:0] macd_sat;
  logic signed [PRICE_BITS+1:0] hist_now;

  // configuration writes; indexes past the list are ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      fast_period <= FAST_PERIOD_RST;
      slow_period <= SLOW_PERIOD_RST;
      signal_len  <= SIGNAL_LEN_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_FAST:   fast_period <= cfg_data[FAST_PERIOD_BITS-1:0];
        REG_SLOW:   slow_period <= cfg_data[SLOW_PERIOD_BITS-1:0];
        REG_SIGNAL: signal_len  <= cfg_data[SIGNAL_LEN_BITS-1:0];
        default: ;
      endcase
    end
  end

  // effective periods and series position checks
  assign fast_eff       = eff_period(CFG_DATA_BITS'(fast_period));
  assign slow_eff       = eff_period(CFG_DATA_BITS'(slow_period));
  assign sig_eff        = eff_period(CFG_DATA_BITS'(signal_len));
  assign period_err_now = fast_eff >= slow_eff;
  assign count_ext      = CMPW'(count);
  assign macd_on        = count_ext >= CMPW'(slow_eff);
  assign k_pos          = count_ext - CMPW'(slow_eff) + CMPW'(1);
  assign sig_on         = macd_on && (k_pos >= CMPW'(sig_eff));

  assign accept = samples.valid && samples.ready;
  assign samples.ready = (state == S_IDLE);

  // sample count after an optional series clear
  assign count_base = samples.series_start ? '0 : count;
  assign count_inc  = (count_base < COUNT_MAX) ? count_base + COUNT_BITS'(1) : count_base;

  // operand select for the unit being updated
  always_comb begin
    acc_cur = fast_acc;
    x_cur   = signed'({{(ACC_BITS - PRICE_BITS){1'b0}}, price_q});
    pos_cur = count_ext;
    n_cur   = fast_eff;
    unique case (unit)
      U_FAST: ;
      U_SLOW: begin
        acc_cur = slow_acc;
        n_cur   = slow_eff;
      end
      U_SIG: begin
        acc_cur = sig_acc;
        x_cur   = signed'({{(ACC_BITS - PRICE_BITS - 1){macd_q[PRICE_BITS]}}, macd_q});
        pos_cur = k_pos;
        n_cur   = sig_eff;
      end
      default: ;
    endcase
  end

  // seed sum, seed mean or ema step
  assign sum_cur   = acc_cur + x_cur;
  assign diff2     = (x_cur - acc_cur) <<< 1;
  assign pos_lt    = pos_cur < CMPW'(n_cur);
  assign pos_eq    = pos_cur == CMPW'(n_cur);
  assign n_den     = DEN_BITS'(n_cur);
  assign div_den   = pos_eq ? n_den : n_den + DEN_BITS'(1);
  assign div_num   = pos_eq ? sum_cur : diff2;
  assign div_start = (state == S_PREP) && !pos_lt;
  assign div_update = addback ? acc_cur + div_quot : div_quot;

  macdema_div #(
    .NUM_BITS (ACC_BITS),
    .DEN_BITS (DEN_BITS)
  ) u_div (
    .clk    (clk),
    .rst    (rst),
    .start  (div_start),
    .num    (div_num),
    .den    (div_den),
    .quot   (div_quot),
    .status (div_stat)
  );

  // where the sequence goes once the current unit is written
  always_comb begin
    adv_state = S_PREP;
    adv_unit  = U_SLOW;
    unique case (unit)
      U_FAST: ;
      U_SLOW: begin
        adv_state = macd_on ? S_MACD : S_OUT;
        adv_unit  = U_SLOW;
      end
      U_SIG: begin
        adv_state = S_OUT;
        adv_unit  = U_SIG;
      end
      default: ;
    endcase
  end

  // saturated macd and histogram
  assign macd_diff = fast_acc - slow_acc;
  always_comb begin
    macd_sat = macd_diff;
    if (macd_diff < MACD_LO) macd_sat = MACD_LO;
    else if (macd_diff > MACD_HI) macd_sat = MACD_HI;
  end
  assign hist_now = signed'({macd_q[PRICE_BITS], macd_q})
                  - signed'(sig_acc[PRICE_BITS+1:0]);

  // sequencer, running state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      unit      <= U_FAST;
      count     <= '0;
      fast_acc  <= '0;
      slow_acc  <= '0;
      sig_acc   <= '0;
      item_err  <= 1'b0;
      addback   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      // taken result frees the register unless a new one is written now
      if (results.valid && results.ready && state != S_OUT) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (samples.valid) begin
            price_q  <= samples.price;
            item_err <= period_err_now;
            unit     <= U_FAST;
            if (samples.series_start) begin
              fast_acc <= '0;
              slow_acc <= '0;
              sig_acc  <= '0;
            end
            if (!period_err_now) count <= count_inc;
            else if (samples.series_start) count <= '0;
            state <= period_err_now ? S_OUT : S_PREP;
          end
        end
        S_PREP: begin
          addback <= !pos_eq;
          if (pos_lt) begin
            unique case (unit)
              U_FAST:  fast_acc <= sum_cur;
              U_SLOW:  slow_acc <= sum_cur;
              U_SIG:   sig_acc  <= sum_cur;
              default: ;
            endcase
            unit  <= adv_unit;
            state <= adv_state;
          end else begin
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_stat.done) begin
            unique case (unit)
              U_FAST:  fast_acc <= div_update;
              U_SLOW:  slow_acc <= div_update;
              U_SIG:   sig_acc  <= div_update;
              default: ;
            endcase
            unit  <= adv_unit;
            state <= adv_state;
          end
        end
        S_MACD: begin
          macd_q <= macd_sat[PRICE_BITS:0];
          unit   <= U_SIG;
          state  <= S_PREP;
        end
        S_OUT: begin
          if (!out_valid || results.ready) begin
            out_valid <= 1'b1;
            out_perr  <= item_err;
            out_mv    <= !item_err && macd_on;
            out_sv    <= !item_err && sig_on;
            out_macd  <= (!item_err && macd_on) ? macd_q : '0;
            out_sig   <= (!item_err && sig_on) ? signed'(sig_acc[PRICE_BITS:0]) : '0;
            out_hist  <= (!item_err && sig_on) ? hist_now : '0;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // result channel
  assign results.valid           = out_valid;
  assign results.macd_valid      = out_mv;
  assign results.macd_value      = out_macd;
  assign results.signal_valid    = out_sv;
  assign results.signal_value    = out_sig;
  assign results.histogram_value = out_hist;
  assign results.period_error    = out_perr;

  // checks
  `MACDEMA_ASSERT_SAME(a_div_busy, clk, rst, div_stat.busy, state == S_DIV, "div busy")
  `MACDEMA_ASSERT_NEXT(a_err_out, clk, rst, accept && period_err_now, state == S_OUT, "err path")
  `MACDEMA_ASSERT_NEXT(a_count, clk, rst, accept && !period_err_now, count != '0, "count zero")
  `MACDEMA_ASSERT_SAME(a_sig_macd, clk, rst, out_valid && out_sv, out_mv, "signal w/o macd")
  `MACDEMA_ASSERT_SAME(a_err_flags, clk, rst, out_valid && out_perr, !out_mv && !out_sv, "err flags")

endmodule

// ===== rtl/macdema_div.sv =====
// ----------------------------------------------------------------------------
// MACD EMA stream divider
// Radix-2 restoring divider, one quotient bit per cycle, rounding the signed
// quotient to nearest with ties away from zero.
// ----------------------------------------------------------------------------
module macdema_div #(
  parameter int NUM_BITS = macdema_pkg::ACC_BITS_DEF,
  parameter int DEN_BITS = macdema_pkg::DEN_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic signed [NUM_BITS-1:0] num,
  input  logic        [DEN_BITS-1:0] den,
  output logic signed [NUM_BITS-1:0] quot,
  output macdema_pkg::div_status_t   status
);
  import macdema_pkg::*;

  localparam int CNT_BITS = $clog2(NUM_BITS + 1);

  logic                busy;
  logic                fin;
  logic                done;
  logic [CNT_BITS-1:0] cnt;
  logic [DEN_BITS-1:0] rem;
  logic [DEN_BITS-1:0] den_q;
  logic [NUM_BITS-1:0] quo;
  logic                neg;

  logic [NUM_BITS-1:0] num_abs;
  logic [NUM_BITS-1:0] mag;
  logic [DEN_BITS:0]   trial;
  logic                fits;

  // magnitude plus half the divisor gives round-half-away after truncation
  assign num_abs = num[NUM_BITS-1] ? NUM_BITS'(-num) : NUM_BITS'(num);
  assign mag     = num_abs + NUM_BITS'(den >> 1);

  // one restoring step
  assign trial = {rem, quo[NUM_BITS-1]};
  assign fits  = trial >= {1'b0, den_q};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fin  <= 1'b0;
      done <= 1'b0;
    end else begin
      // last quotient bit, then the signed result in the cycle after
      fin  <= busy && !start && (cnt == CNT_BITS'(1));
      done <= fin;
      if (start) begin
        busy  <= 1'b1;
        neg   <= num[NUM_BITS-1];
        quo   <= mag;
        rem   <= '0;
        den_q <= den;
        cnt   <= CNT_BITS'(NUM_BITS);
      end else if (busy) begin
        rem <= fits ? DEN_BITS'(trial - {1'b0, den_q}) : trial[DEN_BITS-1:0];
        quo <= {quo[NUM_BITS-2:0], fits};
        cnt <= cnt - CNT_BITS'(1);
        if (cnt == CNT_BITS'(1)) busy <= 1'b0;
      end
      // apply the sign once all bits are in
      if (fin) quot <= neg ? signed'(-quo) : signed'(quo);
    end
  end

  assign status.busy = busy;
  assign status.done = done;

endmodule
